>>> rtl/sorm_pkg.sv
// shared types and constants of the sorted offset range map
package sorm_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ROW_W  = 32;
    localparam int COL_W  = 16;
    localparam int KEY_W  = ROW_W + COL_W;
    localparam int ROFF_W = ROW_W + 1;
    localparam int COFF_W = COL_W + 1;

    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_MAP    = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_ORDER = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_SAT   = 2'd3;

    // one stored breakpoint, offsets in two's complement
    typedef struct packed {
        logic [KEY_W-1:0]  pos;
        logic [ROFF_W-1:0] roff;
        logic [COFF_W-1:0] coff;
    } entry_t;

    // search token handed from one cell to the next
    typedef struct packed {
        logic              tok;
        logic              found;
        logic [ROFF_W-1:0] roff;
        logic [COFF_W-1:0] coff;
    } link_t;

endpackage

>>> rtl/sorm_req_if.sv
// request channel: valid, ready and the request payload
interface sorm_req_if;
    import sorm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [ROW_W-1:0]         pos_row;
    logic [COL_W-1:0]         pos_col;
    logic signed [ROFF_W-1:0] row_delta;
    logic signed [COFF_W-1:0] col_delta;

    modport source (output valid, req_type, pos_row, pos_col, row_delta, col_delta,
                    input ready);
    modport sink   (input valid, req_type, pos_row, pos_col, row_delta, col_delta,
                    output ready);
endinterface

>>> rtl/sorm_res_if.sv
// result channel: valid, ready and the result payload
interface sorm_res_if;
    import sorm_pkg::*;

    logic             valid;
    logic             ready;
    logic [ROW_W-1:0] mapped_row;
    logic [COL_W-1:0] mapped_col;
    logic [1:0]       status;

    modport source (output valid, mapped_row, mapped_col, status, input ready);
    modport sink   (input valid, mapped_row, mapped_col, status, output ready);
endinterface

>>> rtl/sorm_cell.sv
// one breakpoint cell: holds an entry and updates the passing search token
module sorm_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  sorm_pkg::entry_t          wr_entry,
    input  logic                      live,
    input  logic [sorm_pkg::KEY_W-1:0] key,
    input  sorm_pkg::link_t           prev,
    output sorm_pkg::link_t           next
);
    import sorm_pkg::*;

    entry_t            ent_reg;
    logic              tok_reg;
    logic              found_reg;
    logic [ROFF_W-1:0] roff_reg;
    logic [COFF_W-1:0] coff_reg;
    logic              hit;

    // entries are sorted, so the last hit along the chain is the greatest one
    assign hit = live && (ent_reg.pos <= key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= prev.tok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ent_reg <= wr_entry;
        end
        if (prev.tok)
        begin
            found_reg <= hit || prev.found;
            roff_reg  <= hit ? ent_reg.roff : prev.roff;
            coff_reg  <= hit ? ent_reg.coff : prev.coff;
        end
    end

    assign next.tok   = tok_reg;
    assign next.found = found_reg;
    assign next.roff  = roff_reg;
    assign next.coff  = coff_reg;
endmodule

>>> rtl/sorted_offset_range_map.sv
// Sorted offset range map: a table of up to TABLE_DEPTH breakpoints, each in a cell of a
// chain. An append, clear or unused request has its result registered and ready in the
// next cycle. A map request launches a token that walks the cell chain one cell per cycle;
// its result is registered once the token leaves the last cell of the chain.
// A new request is taken once the previous result has left or leaves in the same cycle.
// Appends must arrive in strictly increasing (row, col) order; a query takes the offsets of
// the greatest breakpoint at or below it, or passes unchanged, and saturates the result.
module sorted_offset_range_map (
    input  logic       clk,
    input  logic       rst_n,
    sorm_req_if.sink   req,
    sorm_res_if.source res
);
    import sorm_pkg::*;

    typedef enum logic {ST_IDLE, ST_SEARCH} state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic [KEY_W-1:0] last_pos_reg;
    logic [KEY_W-1:0] key_reg;
    logic             start_reg;
    logic             res_valid_reg;
    logic [ROW_W-1:0] res_row_reg;
    logic [COL_W-1:0] res_col_reg;
    logic [1:0]       res_status_reg;

    logic             req_fire;
    logic             res_fire;
    logic             res_load;
    logic [KEY_W-1:0] in_key;
    logic             out_of_order;
    logic             table_full;
    logic             append_ok;
    logic [1:0]       append_status;
    entry_t           wr_entry;

    link_t            chain [0:TABLE_DEPTH];
    link_t            tail;

    logic [ROW_W+1:0] row_sum;
    logic [COL_W+1:0] col_sum;
    logic [ROW_W-1:0] row_map;
    logic [COL_W-1:0] col_map;
    logic [1:0]       map_status;

    assign req_fire = req.valid && req.ready;
    assign res_fire = res.valid && res.ready;
    assign req.ready = (state_reg == ST_IDLE) && (!res_valid_reg || res.ready);

    assign in_key       = {req.pos_row, req.pos_col};
    assign out_of_order = (count_reg != '0) && (in_key <= last_pos_reg);
    assign table_full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign append_ok    = req_fire && (req.req_type == REQ_APPEND)
                          && !out_of_order && !table_full;
    assign append_status = out_of_order ? STAT_ORDER : (table_full ? STAT_FULL : STAT_OK);

    // a result is loaded for every non-map transfer and at the end of a search
    assign res_load = (req_fire && (req.req_type != REQ_MAP))
                      || ((state_reg == ST_SEARCH) && tail.tok);

    assign wr_entry.pos  = in_key;
    assign wr_entry.roff = req.row_delta;
    assign wr_entry.coff = req.col_delta;

    assign chain[0].tok   = start_reg;
    assign chain[0].found = 1'b0;
    assign chain[0].roff  = '0;
    assign chain[0].coff  = '0;

    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        sorm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (append_ok && (count_reg == CNT_W'(i))),
            .wr_entry (wr_entry),
            .live     (count_reg > CNT_W'(i)),
            .key      (key_reg),
            .prev     (chain[i]),
            .next     (chain[i+1])
        );
    end

    assign tail = chain[TABLE_DEPTH];

    // key zero-extended, offset sign-extended: top bit marks negative, next bit overflow
    assign row_sum = {2'b00, key_reg[KEY_W-1:COL_W]} + {tail.roff[ROFF_W-1], tail.roff};
    assign col_sum = {2'b00, key_reg[COL_W-1:0]} + {tail.coff[COFF_W-1], tail.coff};

    always_comb
    begin
        map_status = STAT_OK;
        if (!tail.found)
        begin
            row_map = key_reg[KEY_W-1:COL_W];
            col_map = key_reg[COL_W-1:0];
        end
        else
        begin
            if (row_sum[ROW_W+1])
            begin
                row_map    = '0;
                map_status = STAT_SAT;
            end
            else if (row_sum[ROW_W])
            begin
                row_map    = '1;
                map_status = STAT_SAT;
            end
            else
            begin
                row_map = row_sum[ROW_W-1:0];
            end
            if (col_sum[COL_W+1])
            begin
                col_map    = '0;
                map_status = STAT_SAT;
            end
            else if (col_sum[COL_W])
            begin
                col_map    = '1;
                map_status = STAT_SAT;
            end
            else
            begin
                col_map = col_sum[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            last_pos_reg   <= '0;
            key_reg        <= '0;
            start_reg      <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_row_reg    <= '0;
            res_col_reg    <= '0;
            res_status_reg <= STAT_OK;
        end
        else
        begin
            start_reg <= req_fire && (req.req_type == REQ_MAP);
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_fire)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_fire)
                    begin
                        res_row_reg    <= '0;
                        res_col_reg    <= '0;
                        res_status_reg <= (req.req_type == REQ_APPEND) ? append_status
                                                                       : STAT_OK;
                        case (req.req_type)
                            REQ_APPEND:
                            begin
                                if (append_ok)
                                begin
                                    count_reg    <= count_reg + CNT_W'(1);
                                    last_pos_reg <= in_key;
                                end
                            end
                            REQ_MAP:
                            begin
                                key_reg   <= in_key;
                                state_reg <= ST_SEARCH;
                            end
                            REQ_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SEARCH:
                begin
                    if (tail.tok)
                    begin
                        res_row_reg    <= row_map;
                        res_col_reg    <= col_map;
                        res_status_reg <= map_status;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res.valid      = res_valid_reg;
    assign res.mapped_row = res_row_reg;
    assign res.mapped_col = res_col_reg;
    assign res.status     = res_status_reg;
endmodule

>>> rtl/sorm_checker.sv
// port-level checks of the sorted offset range map, bound to the top level
module sorm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic [1:0]                  req_type,
    input logic                        res_valid,
    input logic                        res_ready,
    input logic [sorm_pkg::ROW_W-1:0]  mapped_row,
    input logic [sorm_pkg::COL_W-1:0]  mapped_col,
    input logic [1:0]                  status
);
    import sorm_pkg::*;

    logic       pending_reg;
    logic [1:0] last_req_reg;
    logic       req_fire;
    logic       res_fire;

    assign req_fire = req_valid && req_ready;
    assign res_fire = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg  <= 1'b0;
            last_req_reg <= REQ_APPEND;
        end
        else
        begin
            if (req_fire)
            begin
                pending_reg  <= 1'b1;
                last_req_reg <= req_type;
            end
            else if (res_fire)
            begin
                pending_reg <= 1'b0;
            end
        end
    end

    // a stalled result holds its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(mapped_row)
            && $stable(mapped_col) && $stable(status))
        else $error("result changed while stalled");

    // only one request in flight at a time
    a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |-> !pending_reg || res_fire)
        else $error("request taken while previous result outstanding");

    // only map requests return mapped values
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && last_req_reg != REQ_MAP |-> mapped_row == '0 && mapped_col == '0)
        else $error("nonzero mapped value for non-map request");

    // status codes belong to the request kind
    a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> status == STAT_OK
            || (last_req_reg == REQ_MAP && status == STAT_SAT)
            || (last_req_reg == REQ_APPEND && (status == STAT_ORDER || status == STAT_FULL)))
        else $error("status does not match request kind");
endmodule

bind sorted_offset_range_map sorm_checker u_sorm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .req_type   (req.req_type),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .mapped_row (res.mapped_row),
    .mapped_col (res.mapped_col),
    .status     (res.status)
);

>>> test/sorted_offset_range_map_tb.sv
// testbench for the sorted offset range map: directed, full-table, stall and random requests
module sorted_offset_range_map_tb;
    import sorm_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int ITEM_TARGET = 1650;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 600;
    localparam int REPORT_MAX  = 10;

    localparam logic signed [ROFF_W-1:0] ROFF_MIN = {1'b1, {ROW_W{1'b0}}};
    localparam logic signed [ROFF_W-1:0] ROFF_MAX = {1'b0, {ROW_W{1'b1}}};
    localparam logic signed [COFF_W-1:0] COFF_MIN = {1'b1, {COL_W{1'b0}}};
    localparam logic signed [COFF_W-1:0] COFF_MAX = {1'b0, {COL_W{1'b1}}};

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [1:0]       status;
    } map_result_t;

    logic clk = 1'b0;
    logic rst_n;

    sorm_req_if req_bus ();
    sorm_res_if res_bus ();

    sorted_offset_range_map DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus.sink),
        .res   (res_bus.source)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor copy of the breakpoint table
    logic [KEY_W-1:0]         bp_key  [TABLE_DEPTH];
    logic signed [ROFF_W-1:0] bp_roff [TABLE_DEPTH];
    logic signed [COFF_W-1:0] bp_coff [TABLE_DEPTH];
    int unsigned              bp_count;

    map_result_t      pending_results [$];
    logic [KEY_W-1:0] seq_keys [$];

    int  error_count    = 0;
    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  hold_left      = 0;
    bit  no_idle        = 1'b0;

    int  n_append, n_map, n_clear, n_unused;
    int  n_order, n_full, n_sat, n_passthru, peak_fill;

    function automatic logic [KEY_W-1:0] rand_key();
        return {$urandom(), 16'($urandom())};
    endfunction

    function automatic logic signed [ROFF_W-1:0] rand_roff();
        int d;
        d = int'($urandom_range(0, 2000)) - 1000;
        if ($urandom_range(0, 3) == 0)
            return {1'($urandom_range(0, 1)), $urandom()};
        return ROFF_W'(d);
    endfunction

    function automatic logic signed [COFF_W-1:0] rand_coff();
        int d;
        d = int'($urandom_range(0, 2000)) - 1000;
        if ($urandom_range(0, 3) == 0)
            return COFF_W'($urandom());
        return COFF_W'(d);
    endfunction

    // works out the result of one request and updates the table copy
    function automatic map_result_t predict_request(input logic [1:0] kind,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic signed [ROFF_W-1:0] roff,
                                                    input logic signed [COFF_W-1:0] coff);
        map_result_t rs;
        int          hit;
        longint      r;
        longint      c;
        rs = '0;
        case (kind)
            REQ_APPEND:
            begin
                if (bp_count > 0 && key <= bp_key[bp_count-1])
                    rs.status = STAT_ORDER;
                else if (bp_count >= TABLE_DEPTH)
                    rs.status = STAT_FULL;
                else
                begin
                    bp_key[bp_count]  = key;
                    bp_roff[bp_count] = roff;
                    bp_coff[bp_count] = coff;
                    bp_count++;
                end
            end
            REQ_MAP:
            begin
                hit = -1;
                for (int i = 0; i < int'(bp_count); i++)
                    if (bp_key[i] <= key)
                        hit = i;
                if (hit < 0)
                begin
                    rs.row = key[KEY_W-1:COL_W];
                    rs.col = key[COL_W-1:0];
                end
                else
                begin
                    r = longint'({1'b0, key[KEY_W-1:COL_W]}) + longint'(bp_roff[hit]);
                    c = longint'({1'b0, key[COL_W-1:0]}) + longint'(bp_coff[hit]);
                    if (r < 0 || r > longint'(64'hFFFF_FFFF)
                        || c < 0 || c > longint'(64'hFFFF))
                        rs.status = STAT_SAT;
                    rs.row = (r < 0) ? '0 : (r > longint'(64'hFFFF_FFFF)) ? '1 : ROW_W'(r);
                    rs.col = (c < 0) ? '0 : (c > longint'(64'hFFFF)) ? '1 : COL_W'(c);
                end
            end
            REQ_CLEAR:
                bp_count = 0;
            default:
                ;
        endcase
        return rs;
    endfunction

    task automatic send_req(input logic [1:0] kind, input logic [KEY_W-1:0] key,
                            input logic signed [ROFF_W-1:0] roff,
                            input logic signed [COFF_W-1:0] coff);
        map_result_t want;
        while (!no_idle && $urandom_range(0, 99) < 20)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= kind;
        req_bus.pos_row   <= key[KEY_W-1:COL_W];
        req_bus.pos_col   <= key[COL_W-1:0];
        req_bus.row_delta <= roff;
        req_bus.col_delta <= coff;
        do
            @(posedge clk);
        while (req_bus.ready !== 1'b1);

        want = predict_request(kind, key, roff, coff);
        pending_results.insert(pending_results.size(), want);
        if (kind != REQ_UNUSED)
            items_sent++;
        case (kind)
            REQ_APPEND: n_append++;
            REQ_MAP:    n_map++;
            REQ_CLEAR:  n_clear++;
            default:    n_unused++;
        endcase
        if (want.status == STAT_ORDER) n_order++;
        if (want.status == STAT_FULL)  n_full++;
        if (want.status == STAT_SAT)   n_sat++;
        if (kind == REQ_MAP && want.status == STAT_OK && want.row == key[KEY_W-1:COL_W]
            && want.col == key[COL_W-1:0])
            n_passthru++;
        if (int'(bp_count) > peak_fill)
            peak_fill = bp_count;
    endtask

    function automatic logic [KEY_W-1:0] pick_query();
        int idx;
        if (seq_keys.size() == 0)
            return rand_key();
        idx = $urandom_range(0, seq_keys.size() - 1);
        case ($urandom_range(0, 6))
            0: return seq_keys[idx];
            1: return seq_keys[idx] + 48'd1;
            2: return seq_keys[idx] - 48'd1;
            3: return seq_keys[0] - 48'd1;
            4: return seq_keys[$] + 48'($urandom_range(0, 1000));
            5: return $urandom_range(0, 1) ? '0 : '1;
            default: return rand_key();
        endcase
    endfunction

    // random request of any kind, often with a key at or below the last key
    task automatic noise_item();
        logic [1:0]       kind;
        logic [KEY_W-1:0] k;
        kind = 2'($urandom_range(0, 3));
        if (seq_keys.size() != 0 && $urandom_range(0, 1) == 1)
            k = seq_keys[$] - 48'($urandom_range(0, 3));
        else
            k = rand_key();
        send_req(kind, k, rand_roff(), rand_coff());
    endtask

    task automatic test_directed();
        send_req(REQ_MAP, '0, '0, '0);
        send_req(REQ_MAP, '1, '0, '0);
        send_req(REQ_UNUSED, rand_key(), rand_roff(), rand_coff());
        send_req(REQ_APPEND, {32'd100, 16'd50}, 33'sd1000, -17'sd20);
        send_req(REQ_APPEND, {32'd100, 16'd50}, '0, '0);
        send_req(REQ_APPEND, {32'd99, 16'hFFFF}, '0, '0);
        send_req(REQ_MAP, {32'd100, 16'd49}, '0, '0);
        send_req(REQ_MAP, {32'd100, 16'd50}, '0, '0);
        send_req(REQ_MAP, {32'd100, 16'd60}, '0, '0);
        send_req(REQ_APPEND, {32'd200, 16'd0}, ROFF_MIN, COFF_MAX);
        send_req(REQ_MAP, {32'd300, 16'd1}, '0, '0);
        send_req(REQ_MAP, {32'hFFFF_FFFF, 16'd0}, '0, '0);
        send_req(REQ_APPEND, {32'h8000_0000, 16'd0}, ROFF_MAX, COFF_MIN);
        send_req(REQ_MAP, {32'h8000_0000, 16'd0}, '0, '0);
        send_req(REQ_APPEND, '1, '0, '0);
        send_req(REQ_MAP, '1, ROFF_MAX, COFF_MAX);
        send_req(REQ_APPEND, '1, '0, '0);
        send_req(REQ_CLEAR, rand_key(), rand_roff(), rand_coff());
        send_req(REQ_MAP, {32'd500, 16'd5}, '0, '0);
        // key zero is legal again once the table is empty
        send_req(REQ_APPEND, '0, 33'sd7, -17'sd3);
        send_req(REQ_MAP, '0, '0, '0);
        send_req(REQ_MAP, {32'd0, 16'd100}, '0, '0);
    endtask

    task automatic test_full_table();
        logic [KEY_W-1:0] k;
        send_req(REQ_CLEAR, '0, '0, '0);
        seq_keys.delete();
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            k = {32'(i * 16_000_000 + $urandom_range(0, 15_000_000)), 16'($urandom())};
            send_req(REQ_APPEND, k, rand_roff(), rand_coff());
            seq_keys.insert(seq_keys.size(), k);
        end
        send_req(REQ_APPEND, '1, '0, '0);
        send_req(REQ_APPEND, seq_keys[$], '0, '0);
        send_req(REQ_APPEND, seq_keys[0], '0, '0);
        repeat (6)
            send_req(REQ_MAP, pick_query(), rand_roff(), rand_coff());
    endtask

    task automatic test_stalled_output();
        // receiver holds off while requests keep coming, so the block backs up
        hold_left = HOLD_CYCLES;
        repeat (8)
        begin
            if ($urandom_range(0, 1) == 1)
                send_req(REQ_MAP, pick_query(), '0, '0);
            else
                noise_item();
        end
    endtask

    task automatic run_breakpoint_set();
        int               n;
        logic [KEY_W-1:0] stride;
        logic [KEY_W-1:0] k;
        send_req(REQ_CLEAR, rand_key(), rand_roff(), rand_coff());
        seq_keys.delete();
        n = ($urandom_range(0, 24) == 0) ? $urandom_range(200, TABLE_DEPTH + 2)
                                         : $urandom_range(1, 12);
        case ($urandom_range(0, 2))
            0:       stride = 48'd4;
            1:       stride = 48'h4_0000;
            default: stride = 48'h7FFF_FFFF_FFFF / n;
        endcase
        k = rand_key() >> 1;
        for (int i = 0; i < n; i++)
        begin
            k = k + 48'd1 + (rand_key() % stride);
            send_req(REQ_APPEND, k, rand_roff(), rand_coff());
            seq_keys.insert(seq_keys.size(), k);
            if ($urandom_range(0, 9) == 0)
                noise_item();
        end
        repeat ($urandom_range(1, 6))
            send_req(REQ_MAP, pick_query(), rand_roff(), rand_coff());
    endtask

    task automatic test_random();
        while (items_sent < ITEM_TARGET)
        begin
            no_idle = (items_sent >= 600 && items_sent < 900);
            if ($urandom_range(0, 99) < 75)
                run_breakpoint_set();
            else
                noise_item();
        end
        no_idle = 1'b0;
    endtask

    // result side: ready with random gaps and the long hold-off
    initial
    begin
        res_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_bus.ready <= 1'b0;
                hold_left--;
            end
            else
                res_bus.ready <= no_idle || ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge clk)
    begin : check_results
        map_result_t want;
        map_result_t got;
        if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            got = {res_bus.mapped_row, res_bus.mapped_col, res_bus.status};
            if (pending_results.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result at %0t: row %h col %h status %0d",
                             $time, got.row, got.col, got.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.row !== want.row || got.col !== want.col || got.status !== want.status)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch at %0t: expected %h %h %0d, got %h %h %0d",
                                 $time, want.row, want.col, want.status,
                                 got.row, got.col, got.status);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            || (res_bus.valid === 1'b1 && res_bus.ready === 1'b1))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT)
        begin
            $display("timeout after %0d cycles with no transfer", quiet);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.req_type  <= REQ_APPEND;
        req_bus.pos_row   <= '0;
        req_bus.pos_col   <= '0;
        req_bus.row_delta <= '0;
        req_bus.col_delta <= '0;
        bp_count  = 0;
        n_append  = 0;
        n_map     = 0;
        n_clear   = 0;
        n_unused  = 0;
        n_order   = 0;
        n_full    = 0;
        n_sat     = 0;
        n_passthru = 0;
        peak_fill = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_table();
        test_stalled_output();
        test_random();

        req_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 20)
            @(posedge clk);
        error_count += pending_results.size();

        $display("run covered %0d appends, %0d maps, %0d clears, %0d unused requests",
                 n_append, n_map, n_clear, n_unused);
        $display("  %0d out-of-order, %0d full, %0d saturated, %0d pass-through, peak %0d",
                 n_order, n_full, n_sat, n_passthru, peak_fill);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
